// File: src/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and codes for the binding slot allocator
// Request and status codes, field widths and the request/response structs
// passed between the top level and the slot table.
// ----------------------------------------------------------------------------
package bsa_pkg;

  // Field widths
  localparam int TYPE_W     = 3;
  localparam int ID_W       = 32;
  localparam int WANT_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 6;

  // Default table size (1 to 64)
  localparam int NUM_SLOTS_DEF = 32;

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_ACQ_ANY  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_ACQ_SPEC = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_LOOKUP   = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_RELEASE  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_CLEAR    = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE_FREE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED     = 3'd5;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [ID_W-1:0]   resource_id;
    logic [WANT_W-1:0] wanted_slot;
  } bsa_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
  } bsa_rsp_t;

endpackage

// File: src/bsa_slot_table.sv
// ----------------------------------------------------------------------------
// bsa_slot_table: slot state and combinational request resolution
// Holds used / owner / owner-valid per slot, compares the id against all
// owners in parallel, picks the lowest match, lowest free or wanted slot and
// commits the table update on the same edge that the result is registered.
// ----------------------------------------------------------------------------
module bsa_slot_table #(
  parameter int NUM_SLOTS = bsa_pkg::NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              commit,
  input  bsa_pkg::bsa_req_t req,
  output bsa_pkg::bsa_rsp_t rsp
);
  import bsa_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [NUM_SLOTS-1:0] ONE_V = NUM_SLOTS'(1);

  // Slot state
  logic [NUM_SLOTS-1:0] slot_used;
  logic [NUM_SLOTS-1:0] owner_valid;
  logic [ID_W-1:0]      slot_owner [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] slot_used_next;
  logic [NUM_SLOTS-1:0] owner_valid_next;
  logic [NUM_SLOTS-1:0] wr_vec;

  // Lookup terms
  logic [NUM_SLOTS-1:0] owner_hit;
  logic [NUM_SLOTS-1:0] owner_oh;
  logic [NUM_SLOTS-1:0] free_vec;
  logic [NUM_SLOTS-1:0] free_oh;
  logic [NUM_SLOTS-1:0] want_hit;
  logic [NUM_SLOTS-1:0] sel_vec;
  logic                 want_in_range;
  logic [IDX_W-1:0]     sel_idx;
  logic                 grant;
  logic [STATUS_W-1:0]  rsp_status;

  // Parallel id compare and decode of the wanted slot
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      owner_hit[i] = owner_valid[i] && (slot_owner[i] == req.resource_id);
      want_hit[i]  = (req.wanted_slot == WANT_W'(i));
    end
  end

  // Lowest-set-bit isolation
  assign free_vec      = ~slot_used;
  assign owner_oh      = owner_hit & (~owner_hit + ONE_V);
  assign free_oh       = free_vec & (~free_vec + ONE_V);
  assign want_in_range = (req.wanted_slot < WANT_W'(NUM_SLOTS));

  // Request decode and next table state
  always_comb begin
    slot_used_next   = slot_used;
    owner_valid_next = owner_valid;
    wr_vec           = '0;
    sel_vec          = '0;
    grant            = 1'b0;
    rsp_status       = ST_NOT_FOUND;
    unique case (req.req_type)
      REQ_ACQ_ANY: begin
        if (|owner_hit) begin
          rsp_status = ST_FOUND;
          sel_vec    = owner_oh;
        end else if (|free_vec) begin
          rsp_status       = ST_GRANTED;
          sel_vec          = free_oh;
          wr_vec           = free_oh;
          grant            = 1'b1;
          slot_used_next   = slot_used | free_oh;
          owner_valid_next = owner_valid | free_oh;
        end else begin
          rsp_status = ST_NONE_FREE;
        end
      end
      REQ_ACQ_SPEC: begin
        if (!want_in_range) begin
          rsp_status = ST_OUT_OF_RANGE;
        end else if (|(slot_used & want_hit)) begin
          rsp_status = ST_NONE_FREE;
        end else begin
          // old slot keeps its used mark but loses its owner
          rsp_status       = ST_GRANTED;
          sel_vec          = want_hit;
          wr_vec           = want_hit;
          grant            = 1'b1;
          slot_used_next   = slot_used | want_hit;
          owner_valid_next = (owner_valid & ~owner_oh) | want_hit;
        end
      end
      REQ_LOOKUP: begin
        if (|owner_hit) begin
          rsp_status = ST_FOUND;
          sel_vec    = owner_oh;
        end
      end
      REQ_RELEASE: begin
        if (|owner_hit) begin
          rsp_status       = ST_FOUND;
          sel_vec          = owner_oh;
          slot_used_next   = slot_used & ~owner_oh;
          owner_valid_next = owner_valid & ~owner_oh;
        end
      end
      REQ_CLEAR: begin
        rsp_status       = ST_CLEARED;
        slot_used_next   = '0;
        owner_valid_next = '0;
      end
      default: begin
        rsp_status = ST_NOT_FOUND;
      end
    endcase
  end

  // One-hot to index; zero when nothing selected
  always_comb begin
    sel_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel_vec[i]) sel_idx = sel_idx | IDX_W'(i);
    end
  end

  assign rsp = {rsp_status, SLOT_OUT_W'(sel_idx)};

  // Mark registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used   <= '0;
      owner_valid <= '0;
    end else if (commit) begin
      slot_used   <= slot_used_next;
      owner_valid <= owner_valid_next;
    end
  end

  // Owner ids, written only on a grant
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (commit && wr_vec[i]) slot_owner[i] <= req.resource_id;
    end
  end

  // An owner-valid slot is always a used slot
  a_valid_implies_used: assert property (@(posedge clk) disable iff (rst)
    (owner_valid & ~slot_used) == '0)
    else $error("owner_valid set on an unused slot");

  // No id owns more than one slot
  a_single_owner: assert property (@(posedge clk) disable iff (rst)
    commit |-> $onehot0(owner_hit))
    else $error("resource id owns more than one slot");

  // A granted slot is used and owned on the next cycle
  a_grant_takes: assert property (@(posedge clk) disable iff (rst)
    (commit && grant) |=>
      ((slot_used & owner_valid & $past(wr_vec)) == $past(wr_vec)))
    else $error("granted slot not marked used and owned");

  // Clear-all empties the table
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (commit && req.req_type == REQ_CLEAR) |=>
      (slot_used == '0 && owner_valid == '0))
    else $error("clear all left slots marked");

endmodule

// File: src/binding_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// binding_slot_allocator_unit: binding slot allocator, top level
// Input register, slot table and output register with valid/stall on both
// channels.
// ----------------------------------------------------------------------------
// Accepts one request per clock while the response side is not stalled and
// returns exactly one response per request, registered through the input
// register and then the output register. Each request is resolved while it
// sits in the input register: the parallel id compare across all NUM_SLOTS
// owners and the lowest-slot priority pick are combinational, and the table
// update lands on the same edge the response is registered, so a back-to-back
// request sees the updated table. Out of reset every slot is free.
module binding_slot_allocator_unit #(
  parameter int NUM_SLOTS = bsa_pkg::NUM_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [bsa_pkg::TYPE_W-1:0]       req_type,
  input  logic [bsa_pkg::ID_W-1:0]         resource_id,
  input  logic [bsa_pkg::WANT_W-1:0]       wanted_slot,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [bsa_pkg::STATUS_W-1:0]     status,
  output logic [bsa_pkg::SLOT_OUT_W-1:0]   slot
);
  import bsa_pkg::*;

  logic     in_vld;
  bsa_req_t in_req;
  bsa_rsp_t tbl_rsp;
  logic     fire;
  logic     req_take;

  // Resolve when the output register is free or being drained
  assign fire      = in_vld && (!rsp_valid || !rsp_stall);
  assign req_stall = in_vld && !fire;
  assign req_take  = req_valid && !req_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req_take) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      in_req.req_type    <= req_type;
      in_req.resource_id <= resource_id;
      in_req.wanted_slot <= wanted_slot;
    end
  end

  // Slot table
  bsa_slot_table #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .commit(fire),
    .req   (in_req),
    .rsp   (tbl_rsp)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status <= tbl_rsp.status;
      slot   <= tbl_rsp.slot;
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for binding_slot_allocator_unit
// Drives acquire, lookup, release, clear and undecoded requests through the valid/stall
// request channel, tracks the slot table in a local predictor and compares
// every response transfer, field by field, in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import bsa_pkg::*;

  localparam int SLOTS        = NUM_SLOTS_DEF;
  localparam int ID_POOL      = 40;   // more ids than slots so the table fills
  localparam int DRAIN_CYCLES = 10;
  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 150;

  // Request codes the block does not decode
  localparam logic [TYPE_W-1:0] REQ_RSVD_LO = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_RSVD_MID = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_RSVD_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [TYPE_W-1:0]     req_type = '0;
  logic [ID_W-1:0]       resource_id = '0;
  logic [WANT_W-1:0]     wanted_slot = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] slot;

  // Predicted slot table
  logic            tbl_used [SLOTS];
  logic [ID_W-1:0] tbl_owner [SLOTS];
  logic            tbl_owned [SLOTS];

  bsa_rsp_t        owed_rsp[$];
  logic [ID_W-1:0] id_pool [ID_POOL];
  int              errors = 0;
  int              cycles = 0;
  bit              sender_gaps = 1'b0;
  bit              receiver_bursts = 1'b0;
  int              hold_request = 0;

  binding_slot_allocator_unit #(.NUM_SLOTS(SLOTS)) dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .resource_id (resource_id),
    .wanted_slot (wanted_slot),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .slot        (slot)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("binding_slot_allocator_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic int owned_slot(logic [ID_W-1:0] id);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_owned[i] && tbl_owner[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_used[i]) return i;
    end
    return -1;
  endfunction

  function automatic void claim_slot(int s, logic [ID_W-1:0] id);
    tbl_used[s]  = 1'b1;
    tbl_owner[s] = id;
    tbl_owned[s] = 1'b1;
  endfunction

  // Applies one request to the table and returns the response it earns
  function automatic bsa_rsp_t resolve_request(logic [TYPE_W-1:0] kind,
                                               logic [ID_W-1:0] id,
                                               logic [WANT_W-1:0] want);
    bsa_rsp_t r;
    int       hit;
    int       hole;
    r.status = ST_NOT_FOUND;
    r.slot   = '0;
    hit      = owned_slot(id);
    case (kind)
      REQ_ACQ_ANY: begin
        if (hit >= 0) begin
          r.status = ST_FOUND;
          r.slot   = SLOT_OUT_W'(hit);
        end else begin
          hole = lowest_free();
          if (hole >= 0) begin
            claim_slot(hole, id);
            r.status = ST_GRANTED;
            r.slot   = SLOT_OUT_W'(hole);
          end else begin
            r.status = ST_NONE_FREE;
          end
        end
      end
      REQ_ACQ_SPEC: begin
        if (int'(want) >= SLOTS) begin
          r.status = ST_OUT_OF_RANGE;
        end else if (tbl_used[want]) begin
          r.status = ST_NONE_FREE;
        end else begin
          // old slot keeps its used mark but loses its owner
          if (hit >= 0) tbl_owned[hit] = 1'b0;
          claim_slot(int'(want), id);
          r.status = ST_GRANTED;
          r.slot   = SLOT_OUT_W'(want);
        end
      end
      REQ_LOOKUP: begin
        if (hit >= 0) begin
          r.status = ST_FOUND;
          r.slot   = SLOT_OUT_W'(hit);
        end
      end
      REQ_RELEASE: begin
        if (hit >= 0) begin
          tbl_used[hit]  = 1'b0;
          tbl_owned[hit] = 1'b0;
          r.status = ST_FOUND;
          r.slot   = SLOT_OUT_W'(hit);
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          tbl_used[i]  = 1'b0;
          tbl_owned[i] = 1'b0;
        end
        r.status = ST_CLEARED;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Predict on each request transfer, check each response transfer
  always @(posedge clk) begin : check_rsp
    bsa_rsp_t want;
    if (!rst && req_valid && !req_stall) begin
      owed_rsp.push_back(resolve_request(req_type, resource_id, wanted_slot));
    end
    if (!rst && rsp_valid && !rsp_stall) begin
      if (owed_rsp.size() == 0) begin
        report_mismatch("response with nothing outstanding, status", status, 0);
      end else begin
        want = owed_rsp.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (slot !== want.slot) report_mismatch("slot", slot, want.slot);
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold on request
  always @(posedge clk) begin : rsp_side
    int hold_left;
    int phase_left;
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left  = 0;
      phase_left = 0;
    end else begin
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (!receiver_bursts) begin
        rsp_stall <= 1'b0;
        phase_left = 0;
      end else if (phase_left > 0) begin
        phase_left--;
      end else if ($urandom_range(0, 1) == 0) begin
        rsp_stall <= 1'b1;
        phase_left = $urandom_range(1, 17) - 1;
      end else begin
        rsp_stall <= 1'b0;
        phase_left = $urandom_range(1, 24) - 1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  // One request transfer, with an optional idle burst ahead of it
  task automatic send_req(logic [TYPE_W-1:0] kind, logic [ID_W-1:0] id,
                          logic [WANT_W-1:0] want);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_valid   <= 1'b1;
    req_type    <= kind;
    resource_id <= id;
    wanted_slot <= want;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, ID_POOL - 1)];
    return $urandom;
  endfunction

  function automatic logic [WANT_W-1:0] pick_want();
    if ($urandom_range(0, 99) < 85) return WANT_W'($urandom_range(0, SLOTS - 1));
    return WANT_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [TYPE_W-1:0] pick_kind(int acq_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < acq_pct) return ($urandom_range(0, 2) == 0) ? REQ_ACQ_SPEC : REQ_ACQ_ANY;
    roll = $urandom_range(0, 99);
    if (roll < 45) return REQ_LOOKUP;
    if (roll < 92) return REQ_RELEASE;
    if (roll < 97) return REQ_CLEAR;
    case ($urandom_range(0, 2))
      0:       return REQ_RSVD_LO;
      1:       return REQ_RSVD_MID;
      default: return REQ_RSVD_HI;
    endcase
  endfunction

  task automatic run_traffic(int n, int acq_pct);
    for (int i = 0; i < n; i++) send_req(pick_kind(acq_pct), pick_id(), pick_want());
  endtask

  // Edge ids, orphaned slots, range limits and undecoded request codes
  task automatic test_directed();
    send_req(REQ_LOOKUP,   32'h0000_0000, 8'd0);
    send_req(REQ_RELEASE,  32'h0000_0000, 8'd0);
    send_req(REQ_ACQ_ANY,  32'h0000_0000, 8'd0);
    send_req(REQ_ACQ_ANY,  32'h0000_0000, 8'd0);
    send_req(REQ_ACQ_ANY,  32'hFFFF_FFFF, 8'hFF);
    send_req(REQ_ACQ_SPEC, 32'hA5A5_5A5A, WANT_W'(SLOTS - 1));
    send_req(REQ_ACQ_SPEC, 32'h0000_0001, WANT_W'(SLOTS));
    send_req(REQ_ACQ_SPEC, 32'h0000_0001, 8'hFF);
    send_req(REQ_ACQ_SPEC, 32'h0000_0001, 8'd1);
    send_req(REQ_ACQ_SPEC, 32'h0000_0000, 8'd0);   // own slot counts as busy
    send_req(REQ_ACQ_SPEC, 32'h0000_0000, 8'd5);   // slot 0 left used, no owner
    send_req(REQ_LOOKUP,   32'h0000_0000, 8'd0);
    send_req(REQ_ACQ_ANY,  32'h0000_0002, 8'd0);
    send_req(REQ_RELEASE,  32'h0000_0000, 8'd0);
    send_req(REQ_RELEASE,  32'h0000_0000, 8'd0);
    send_req(REQ_ACQ_ANY,  32'h0000_0003, 8'd0);
    send_req(REQ_RSVD_LO,  32'hFFFF_FFFF, 8'd2);
    send_req(REQ_RSVD_MID, 32'h0000_0002, 8'd3);
    send_req(REQ_RSVD_HI,  32'h0000_0000, 8'hFF);
    send_req(REQ_LOOKUP,   32'hFFFF_FFFF, 8'd0);
    send_req(REQ_CLEAR,    32'h0000_0000, 8'd0);
    send_req(REQ_LOOKUP,   32'hFFFF_FFFF, 8'd0);
    send_req(REQ_ACQ_ANY,  32'h8000_0000, 8'd0);
    send_req(REQ_CLEAR,    32'hFFFF_FFFF, 8'hFF);
  endtask

  // Balanced mix with idling on both sides
  task automatic test_mixed_traffic();
    sender_gaps     = 1'b1;
    receiver_bursts = 1'b1;
    run_traffic(700, 50);
  endtask

  // Acquire-heavy traffic that fills the table; starts under a long hold
  task automatic test_fill_under_backpressure();
    sender_gaps     = 1'b0;
    receiver_bursts = 1'b0;
    hold_request    = LONG_HOLD;
    run_traffic(60, 80);
    sender_gaps     = 1'b1;
    receiver_bursts = 1'b1;
    run_traffic(390, 80);
  endtask

  // Full rate, no idling on either side
  task automatic test_back_to_back();
    sender_gaps     = 1'b0;
    receiver_bursts = 1'b0;
    run_traffic(676, 60);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i]  = 1'b0;
      tbl_owner[i] = '0;
      tbl_owned[i] = 1'b0;
    end
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = 32'h8000_0000;
    for (int i = 3; i < ID_POOL; i++) id_pool[i] = $urandom;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_mixed_traffic();
    test_fill_under_backpressure();
    test_back_to_back();
    req_valid <= 1'b0;

    while (owed_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("binding_slot_allocator_unit: match");
    end else begin
      $display("binding_slot_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule
